### hdl/r3fft_pkg.sv
// ----------------------------------------------------------------------------
// r3fft_pkg
// Shared types, constants and the twiddle table builder for the radix-3
// butterfly core.
// ----------------------------------------------------------------------------
package r3fft_pkg;

    // Field widths
    localparam int SAMPLE_BITS    = 24;
    localparam int TWIDDLE_BITS   = 18;
    localparam int TW_FRAC        = TWIDDLE_BITS - 1;
    localparam int TWIDDLE_POINTS = 3072;
    localparam int IDX_BITS       = 10;
    localparam int ADDR_BITS      = 12;
    localparam int LEN_BITS       = 12;
    localparam int STRIDE_BITS    = 11;
    localparam int SCALE_BITS     = 24;
    localparam int M_BITS         = 11;
    localparam int T_BITS         = 12;

    // Internal widths: scaled samples, rotated samples, merge accumulators
    localparam int SMP_W = SAMPLE_BITS + 1;
    localparam int ROT_W = SAMPLE_BITS + 2;
    localparam int ACC_W = 48;

    // Twiddle quarter table
    localparam int TW_QUARTER    = TWIDDLE_POINTS / 4;
    localparam int TW_ADDR_BITS  = $clog2(TW_QUARTER);
    localparam int TW_ENTRY_BITS = 2 * TWIDDLE_BITS;
    localparam int TAYLOR_TERMS  = 10;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin 60 degrees, rounded to the twiddle fraction
    localparam int SIN60_Q30 = 929887697;
    localparam int SIN60_RC  = (SIN60_Q30 + (1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);

    // Reciprocal multipliers for divide by three
    localparam int DIV3_LEN_MUL = 2731;   // 12-bit operand, shift 13
    localparam int DIV3_LEN_SH  = 13;
    localparam int DIV3_HI_MUL  = 1366;   // 11-bit operand, shift 12
    localparam int DIV3_HI_SH   = 12;

    // Pipeline depth from input register to output register
    localparam int PIPE_LAST = 17;

    // Register map
    typedef enum logic [1:0] {
        REG_INVERSE_MODE  = 2'd0,
        REG_STAGE_LEN     = 2'd1,
        REG_TWIDDLE_STRIDE = 2'd2,
        REG_INVERSE_SCALE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SMP_W-1:0] re;
        logic [SMP_W-1:0] im;
    } t_cplx;

    typedef struct packed {
        t_cplx a;
        t_cplx b;
        t_cplx c;
    } t_smp;

    typedef struct packed {
        logic [ROT_W-1:0] re;
        logic [ROT_W-1:0] im;
    } t_rot;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] y2_im;
        logic [SAMPLE_BITS-1:0] y2_re;
        logic [SAMPLE_BITS-1:0] y1_im;
        logic [SAMPLE_BITS-1:0] y1_re;
        logic [SAMPLE_BITS-1:0] y0_im;
        logic [SAMPLE_BITS-1:0] y0_re;
    } t_res;

    typedef logic [TW_ENTRY_BITS-1:0] t_tw_tab [TW_QUARTER];

    // Round half up at the twiddle fraction
    function automatic logic signed [ACC_W-1:0] rnd_tw(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v + (ACC_W'(1) <<< (TW_FRAC - 1));
        return s >>> TW_FRAC;
    endfunction

    // Saturate to the sample width
    function automatic logic [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Quarter-wave table of {cos, sin} magnitudes, evaluated at elaboration
    function automatic t_tw_tab build_tw_tab();
        t_tw_tab tab;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ct;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        logic [63:0] cm;
        logic [63:0] sm;
        for (int r = 0; r < TW_QUARTER; r++) begin
            f    = (64'(r) << 32) / 64'(TWIDDLE_POINTS);
            x    = ((f & (Q30_ONE - 64'd1)) * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            st   = x;
            ct   = Q30_ONE;
            ssum = $signed(x);
            csum = $signed(Q30_ONE);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) begin
                    ssum = ssum - $signed(st);
                    csum = csum - $signed(ct);
                end else begin
                    ssum = ssum + $signed(st);
                    csum = csum + $signed(ct);
                end
            end
            cm = (csum < 0) ? 64'd0 : (64'(csum) + (64'd1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
            sm = (ssum < 0) ? 64'd0 : (64'(ssum) + (64'd1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
            tab[r] = {cm[TWIDDLE_BITS-1:0], sm[TWIDDLE_BITS-1:0]};
        end
        return tab;
    endfunction

endpackage

### hdl/r3fft_div.sv
// ----------------------------------------------------------------------------
// r3fft_div
// Pipelined restoring divider, one quotient bit per stage: butterfly index
// divided by the group size m.
// ----------------------------------------------------------------------------
module r3fft_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [r3fft_pkg::IDX_BITS-1:0] i_dividend,
    input  logic [r3fft_pkg::M_BITS-1:0]   i_divisor,
    output logic [r3fft_pkg::IDX_BITS-1:0] o_quot,
    output logic [r3fft_pkg::IDX_BITS-1:0] o_rem
);
    import r3fft_pkg::*;

    logic [M_BITS-1:0]   r_rem [IDX_BITS];
    logic [IDX_BITS-1:0] r_dq  [IDX_BITS];

    for (genvar s = 0; s < IDX_BITS; s++) begin : g_stage
        logic [M_BITS-1:0]   prev_rem;
        logic [IDX_BITS-1:0] prev_dq;
        logic [M_BITS-1:0]   trial;
        logic [M_BITS-1:0]   n_rem;
        logic [IDX_BITS-1:0] n_dq;

        if (s == 0) begin : g_first
            assign prev_rem = '0;
            assign prev_dq  = i_dividend;
        end else begin : g_next
            assign prev_rem = r_rem[s-1];
            assign prev_dq  = r_dq[s-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            trial = {prev_rem[M_BITS-2:0], prev_dq[IDX_BITS-1]};
            if (trial >= i_divisor) begin
                n_rem = trial - i_divisor;
                n_dq  = {prev_dq[IDX_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_dq  = {prev_dq[IDX_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dq[s]  <= n_dq;
            end
        end
    end

    assign o_quot = r_dq[IDX_BITS-1];
    assign o_rem  = r_rem[IDX_BITS-1][IDX_BITS-1:0];

endmodule

### hdl/r3fft_tw_rom.sv
// ----------------------------------------------------------------------------
// r3fft_tw_rom
// Quarter-wave twiddle ROM, {cos, sin} per entry, registered read.
// ----------------------------------------------------------------------------
module r3fft_tw_rom (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [r3fft_pkg::TW_ADDR_BITS-1:0]  i_addr,
    output logic [r3fft_pkg::TW_ENTRY_BITS-1:0] o_data
);
    import r3fft_pkg::*;

    localparam t_tw_tab TW_TAB = build_tw_tab();

    logic [TW_ENTRY_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= TW_TAB[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### hdl/r3fft_rot_lane.sv
// ----------------------------------------------------------------------------
// r3fft_rot_lane
// One twiddle rotation lane: ROM lookup, quadrant fold, complex multiply and
// rounding. Three register stages.
// ----------------------------------------------------------------------------
module r3fft_rot_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [r3fft_pkg::T_BITS-1:0]  i_t,
    input  r3fft_pkg::t_cplx              i_b,
    output r3fft_pkg::t_rot               o_b
);
    import r3fft_pkg::*;

    localparam int PROD_W = SMP_W + TWIDDLE_BITS;

    // Stage 1: quadrant split and ROM read
    logic [1:0]               quad;
    logic [TW_ADDR_BITS-1:0]  raddr;
    logic [TW_ENTRY_BITS-1:0] rom_data;
    logic [1:0]               r1_quad;
    logic                     r1_tzero;
    t_cplx                    r1_b;

    always_comb begin
        if (i_t >= T_BITS'(3 * TW_QUARTER)) begin
            quad = 2'd3;
        end else if (i_t >= T_BITS'(2 * TW_QUARTER)) begin
            quad = 2'd2;
        end else if (i_t >= T_BITS'(TW_QUARTER)) begin
            quad = 2'd1;
        end else begin
            quad = 2'd0;
        end
        raddr = TW_ADDR_BITS'(i_t - T_BITS'(quad) * T_BITS'(TW_QUARTER));
    end

    r3fft_tw_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_addr (raddr),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_quad  <= quad;
            r1_tzero <= (i_t == '0);
            r1_b     <= i_b;
        end
    end

    // Stage 2: quadrant signs, saturation, partial products
    logic signed [TWIDDLE_BITS:0]   cm;
    logic signed [TWIDDLE_BITS:0]   sm;
    logic signed [TWIDDLE_BITS:0]   cr;
    logic signed [TWIDDLE_BITS:0]   ci;
    logic signed [TWIDDLE_BITS-1:0] wr;
    logic signed [TWIDDLE_BITS-1:0] wi;
    logic signed [PROD_W-1:0]       r2_prr;
    logic signed [PROD_W-1:0]       r2_pii;
    logic signed [PROD_W-1:0]       r2_pri;
    logic signed [PROD_W-1:0]       r2_pir;
    logic                           r2_tzero;
    t_cplx                          r2_b;

    always_comb begin
        cm = $signed({1'b0, rom_data[TW_ENTRY_BITS-1:TWIDDLE_BITS]});
        sm = $signed({1'b0, rom_data[TWIDDLE_BITS-1:0]});
        case (r1_quad)
            2'd0:    begin cr = cm;  ci = sm;  end
            2'd1:    begin cr = -sm; ci = cm;  end
            2'd2:    begin cr = -cm; ci = -sm; end
            default: begin cr = sm;  ci = -cm; end
        endcase
        // only +1.0 can overflow the twiddle format
        wr = (cr > $signed((TWIDDLE_BITS+1)'((1 << TW_FRAC) - 1))) ?
             TWIDDLE_BITS'((1 << TW_FRAC) - 1) : cr[TWIDDLE_BITS-1:0];
        wi = (ci > $signed((TWIDDLE_BITS+1)'((1 << TW_FRAC) - 1))) ?
             TWIDDLE_BITS'((1 << TW_FRAC) - 1) : ci[TWIDDLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prr   <= $signed(r1_b.re) * wr;
            r2_pii   <= $signed(r1_b.im) * wi;
            r2_pri   <= $signed(r1_b.re) * wi;
            r2_pir   <= $signed(r1_b.im) * wr;
            r2_tzero <= r1_tzero;
            r2_b     <= r1_b;
        end
    end

    // Stage 3: sum, round, bypass at twiddle index zero
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;
    t_rot                    n_b;
    t_rot                    r_b;

    always_comb begin
        sum_re = rnd_tw(ACC_W'(r2_prr) - ACC_W'(r2_pii));
        sum_im = rnd_tw(ACC_W'(r2_pri) + ACC_W'(r2_pir));
        if (r2_tzero) begin
            n_b.re = ROT_W'($signed(r2_b.re));
            n_b.im = ROT_W'($signed(r2_b.im));
        end else begin
            n_b.re = sum_re[ROT_W-1:0];
            n_b.im = sum_im[ROT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_b = r_b;

endmodule

### hdl/r3fft_merge.sv
// ----------------------------------------------------------------------------
// r3fft_merge
// Radix-3 combine of the direct sample and the two rotated lanes, with
// rounding and saturation. Second register is the output register.
// ----------------------------------------------------------------------------
module r3fft_merge (
    input  logic             i_clk,
    input  logic             i_en,
    input  r3fft_pkg::t_cplx i_a,
    input  r3fft_pkg::t_rot  i_b,
    input  r3fft_pkg::t_rot  i_c,
    output r3fft_pkg::t_res  o_res
);
    import r3fft_pkg::*;

    // Stage 1: sum, difference, centre term and sin 60 products
    logic signed [ROT_W:0]   s_re;
    logic signed [ROT_W:0]   s_im;
    logic signed [ROT_W:0]   d_re;
    logic signed [ROT_W:0]   d_im;
    logic signed [ACC_W-1:0] r_y0_re;
    logic signed [ACC_W-1:0] r_y0_im;
    logic signed [ACC_W-1:0] r_pre_re;
    logic signed [ACC_W-1:0] r_pre_im;
    logic signed [ACC_W-1:0] r_rd_im;
    logic signed [ACC_W-1:0] r_rd_re;

    always_comb begin
        s_re = $signed(i_b.re) + $signed(i_c.re);
        s_im = $signed(i_b.im) + $signed(i_c.im);
        d_re = $signed(i_b.re) - $signed(i_c.re);
        d_im = $signed(i_b.im) - $signed(i_c.im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y0_re  <= ACC_W'($signed(i_a.re)) + ACC_W'(s_re);
            r_y0_im  <= ACC_W'($signed(i_a.im)) + ACC_W'(s_im);
            r_pre_re <= (ACC_W'($signed(i_a.re)) <<< TW_FRAC) - (ACC_W'(s_re) <<< (TW_FRAC - 1));
            r_pre_im <= (ACC_W'($signed(i_a.im)) <<< TW_FRAC) - (ACC_W'(s_im) <<< (TW_FRAC - 1));
            r_rd_im  <= ACC_W'(d_im) * ACC_W'(SIN60_RC);
            r_rd_re  <= ACC_W'(d_re) * ACC_W'(SIN60_RC);
        end
    end

    // Stage 2: round and saturate into the output register
    t_res n_res;
    t_res r_res;

    always_comb begin
        n_res.y0_re = sat_smp(r_y0_re);
        n_res.y0_im = sat_smp(r_y0_im);
        n_res.y1_re = sat_smp(rnd_tw(r_pre_re - r_rd_im));
        n_res.y1_im = sat_smp(rnd_tw(r_pre_im + r_rd_re));
        n_res.y2_re = sat_smp(rnd_tw(r_pre_re + r_rd_im));
        n_res.y2_im = sat_smp(rnd_tw(r_pre_im - r_rd_re));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### hdl/radix3_fft_stage_butterfly_core.sv
// ----------------------------------------------------------------------------
// radix3_fft_stage_butterfly_core
// One radix-3 Stockham butterfly per transfer, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Input stream (s_axis): butterfly index and samples a, b, c per transfer.
// Output stream (m_axis): y0 destination address and outputs y0, y1, y2.
// APB port: inverse_mode at 0x0, stage_len at 0x4, twiddle_stride at 0x8,
// inverse_scale at 0xC; write only while the stream is idle.
// Throughput: one butterfly per cycle unless m_axis stalls. The input
// transfer reaches the offered result through the 10-stage index divider,
// the twiddle address stages and the 3-stage rotation lanes.
// The b and c rotations run in two parallel lanes, each with its own
// twiddle ROM; a merge stage forms the three outputs.
// Reset clears the configuration registers to their defaults and empties
// the pipeline. While the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline holds, bubbles included, and s_axis_tready
// drops until that result is taken.
// ----------------------------------------------------------------------------
module radix3_fft_stage_butterfly_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s_axis_tdata: butterfly_index, a_re, a_im, b_re, b_im, c_re, c_im, pad
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    // m_axis_tdata: dest_index, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import r3fft_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                   r_inv;
    logic [LEN_BITS-1:0]    r_len;
    logic [STRIDE_BITS-1:0] r_stride;
    logic [SCALE_BITS-1:0]  r_scale;
    logic [M_BITS-1:0]      r_m;
    logic [M_BITS-1:0]      n_m;
    logic [2*LEN_BITS-1:0]  len_prod;
    t_reg_idx               reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv    <= 1'b0;
            r_len    <= LEN_BITS'(3);
            r_stride <= STRIDE_BITS'(1024);
            r_scale  <= '1;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_INVERSE_MODE:   r_inv    <= pwdata[0];
                REG_STAGE_LEN:      r_len    <= pwdata[LEN_BITS-1:0];
                REG_TWIDDLE_STRIDE: r_stride <= pwdata[STRIDE_BITS-1:0];
                REG_INVERSE_SCALE:  r_scale  <= pwdata[SCALE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INVERSE_MODE:   prdata = 32'(r_inv);
            REG_STAGE_LEN:      prdata = 32'(r_len);
            REG_TWIDDLE_STRIDE: prdata = 32'(r_stride);
            REG_INVERSE_SCALE:  prdata = 32'(r_scale);
            default:            prdata = '0;
        endcase
    end

    // group size m = stage_len / 3, at least one
    always_comb begin
        len_prod = r_len * (2*LEN_BITS)'(DIV3_LEN_MUL);
        n_m      = M_BITS'(len_prod >> DIV3_LEN_SH);
        if (n_m == '0) begin
            n_m = M_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= M_BITS'(1);
        end else begin
            r_m <= n_m;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together
    // ------------------------------------------------------------------
    logic                en;
    logic [PIPE_LAST:0]  r_vld;

    assign en            = !r_vld[PIPE_LAST] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[PIPE_LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic [IDX_BITS-1:0]    r_idx0;
    logic [SAMPLE_BITS-1:0] r_raw [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx0 <= s_axis_tdata[9:0];
            for (int j = 0; j < 6; j++) begin
                r_raw[j] <= s_axis_tdata[IDX_BITS + j*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Inverse scaling: conjugate and multiply by the reciprocal length
    // ------------------------------------------------------------------
    localparam int SC_PROD_W = 2 * SMP_W;

    logic signed [SMP_W-1:0]     vin   [6];
    logic signed [SC_PROD_W-1:0] sprod [6];
    logic [SMP_W-1:0]            vout  [6];
    t_smp                        n_smp;
    t_smp                        r_smp [15];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            vin[j] = SMP_W'($signed(r_raw[j]));
            if ((j % 2) == 1) begin
                vin[j] = -vin[j];
            end
            sprod[j] = (vin[j] * $signed({1'b0, r_scale})) + (SC_PROD_W'(1) <<< (SCALE_BITS - 1));
            if (r_inv) begin
                vout[j] = sprod[j][SCALE_BITS +: SMP_W];
            end else begin
                vout[j] = SMP_W'($signed(r_raw[j]));
            end
        end
        n_smp.a.re = vout[0];
        n_smp.a.im = vout[1];
        n_smp.b.re = vout[2];
        n_smp.b.im = vout[3];
        n_smp.c.re = vout[4];
        n_smp.c.im = vout[5];
    end

    // sample delay line to the lanes and the merge
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp[0] <= n_smp;
            for (int j = 1; j < 15; j++) begin
                r_smp[j] <= r_smp[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Index split: q = i div m, k = i mod m
    // ------------------------------------------------------------------
    logic [IDX_BITS-1:0] quot;
    logic [IDX_BITS-1:0] krem;

    r3fft_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_idx0),
        .i_divisor  (r_m),
        .o_quot     (quot),
        .o_rem      (krem)
    );

    // destination address and twiddle product
    localparam int TPROD_W = IDX_BITS + STRIDE_BITS;

    logic [TPROD_W-1:0]   r_tprod;
    logic [ADDR_BITS-1:0] r_addr [7];
    logic [IDX_BITS+LEN_BITS-1:0] addr_full;

    assign addr_full = quot * r_len + (IDX_BITS+LEN_BITS)'(krem);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tprod   <= krem * r_stride;
            r_addr[0] <= addr_full[ADDR_BITS-1:0];
            for (int j = 1; j < 7; j++) begin
                r_addr[j] <= r_addr[j-1];
            end
        end
    end

    // twiddle indices modulo 3*1024: fold the upper part by three
    logic [TPROD_W-11:0]     hi;
    logic [2*(TPROD_W-10)-1:0] hq_prod;
    logic [TPROD_W-11:0]     hq;
    logic [TPROD_W-11:0]     hr;
    logic [T_BITS-1:0]       t1;
    logic [T_BITS:0]         t1x2;
    logic [T_BITS-1:0]       r_t1;
    logic [T_BITS-1:0]       r_t2;

    always_comb begin
        hi      = r_tprod[TPROD_W-1:10];
        hq_prod = hi * (2*(TPROD_W-10))'(DIV3_HI_MUL);
        hq      = (TPROD_W-10)'(hq_prod >> DIV3_HI_SH);
        hr      = hi - hq * (TPROD_W-10)'(3);
        t1      = {hr[1:0], r_tprod[9:0]};
        t1x2    = {t1, 1'b0};
        if (t1x2 >= (T_BITS+1)'(TWIDDLE_POINTS)) begin
            t1x2 = t1x2 - (T_BITS+1)'(TWIDDLE_POINTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= t1;
            r_t2 <= t1x2[T_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Rotation lanes and merge
    // ------------------------------------------------------------------
    t_rot b_rot;
    t_rot c_rot;
    t_res res;

    r3fft_rot_lane u_lane_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (r_t1),
        .i_b   (r_smp[11].b),
        .o_b   (b_rot)
    );

    r3fft_rot_lane u_lane_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (r_t2),
        .i_b   (r_smp[11].c),
        .o_b   (c_rot)
    );

    r3fft_merge u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_smp[14].a),
        .i_b   (b_rot),
        .i_c   (c_rot),
        .o_res (res)
    );

    assign m_axis_tdata = {4'b0, res.y2_im, res.y2_re, res.y1_im, res.y1_re,
                           res.y0_im, res.y0_re, r_addr[6]};

endmodule

### hdl/r3fft_chk.sv
// ----------------------------------------------------------------------------
// r3fft_chk
// Port-level checks for the radix-3 butterfly core, bound to the top level.
// ----------------------------------------------------------------------------
module r3fft_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // input back-pressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind radix3_fft_stage_butterfly_core r3fft_chk u_chk (.*);
